// ----- rtl/range_add_range_max_tree_unit_defines.svh -----
// assertion macros for the range add / range max tree unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RANGE_ADD_RANGE_MAX_TREE_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_MAX_TREE_UNIT_DEFINES_SVH

// same-cycle implication
`define RARMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RARMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rarmt_pkg.sv -----
// shared types, codes and helpers for the range add / range max tree unit
// no dependencies
package rarmt_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 64;

  // negated 0x3f3f3f3f3f3f3f3f
  localparam logic [DATA_W-1:0] EMPTY_MAX = 64'hC0C0_C0C0_C0C0_C0C1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MAX   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_CH0,
    ST_CH1,
    ST_POST0,
    ST_POST1,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] pd;
  } node_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] max_value;
    logic              empty;
  } res_t;

  function automatic logic [DATA_W-1:0] smax(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

// ----- rtl/rarmt_mem.sv -----
// node store: one write port, one registered read port, same-address forwarding
// depends on nothing
module rarmt_mem #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // a read that meets a write to the same entry takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ----- rtl/rarmt_stack.sv -----
// walk stack: up to two pushes or one pop per cycle
// depends on nothing
module rarmt_stack #(
  parameter int unsigned EW = 32,
  parameter int unsigned SD = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_a_i,
  input  logic [EW-1:0] data_a_i,
  input  logic          push_b_i,
  input  logic [EW-1:0] data_b_i,
  input  logic          pop_i,
  output logic [EW-1:0] top_o,
  output logic          empty_o
);

  localparam int unsigned PW = $clog2(SD + 1);
  localparam int unsigned IW = $clog2(SD);

  logic [EW-1:0] stk_q [SD];
  logic [PW-1:0] sp_q, sp_d;
  logic [PW-1:0] idx_b;
  logic [PW-1:0] idx_top;

  assign idx_b   = sp_q + PW'(push_a_i);
  assign idx_top = sp_q - PW'(1);
  assign top_o   = stk_q[idx_top[IW-1:0]];
  assign empty_o = (sp_q == '0);

  always_comb begin
    sp_d = sp_q;
    if (pop_i) begin
      sp_d = idx_top;
    end else begin
      sp_d = sp_q + PW'(push_a_i) + PW'(push_b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      stk_q[sp_q[IW-1:0]] <= data_a_i;
    end
    if (push_b_i) begin
      stk_q[idx_b[IW-1:0]] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

endmodule

// ----- rtl/rarmt_ctrl.sv -----
// tree walk sequencer: visits nodes, hands pending adds down, rebuilds maxima
// depends on rarmt_pkg
module rarmt_ctrl #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [rarmt_pkg::IDX_W-1:0]         left_index_i,
  input  logic [rarmt_pkg::IDX_W-1:0]         right_index_i,
  input  logic [rarmt_pkg::DATA_W-1:0]        add_amount_i,
  output logic                                mem_we_o,
  output logic [$clog2(LEAVES):0]             mem_waddr_o,
  output rarmt_pkg::node_t                    mem_wdata_o,
  output logic [$clog2(LEAVES):0]             mem_raddr_o,
  input  rarmt_pkg::node_t                    mem_rdata_i,
  output logic                                push_post_o,
  output logic [3*$clog2(LEAVES)+1:0]         post_entry_o,
  output logic                                push_right_o,
  output logic [3*$clog2(LEAVES)+1:0]         right_entry_o,
  output logic                                pop_o,
  input  logic [3*$clog2(LEAVES)+1:0]         stk_top_i,
  input  logic                                stk_empty_i,
  output rarmt_pkg::res_t                     res_o,
  input  logic                                res_ready_i
);
  import rarmt_pkg::*;

  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned NW = LW + 1;
  localparam int unsigned CW = (LW > IDX_W) ? LW : IDX_W;
  localparam int unsigned EW = 1 + NW + 2 * LW;

  state_e            state_q, state_d;
  logic              post_q, post_d;
  logic [NW-1:0]     node_q, node_d;
  logic [LW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]  ql_q, ql_d, qr_q, qr_d;
  logic [DATA_W-1:0] amt_q, amt_d;
  logic              is_add_q, is_add_d;
  logic [DATA_W-1:0] best_q, best_d;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [NW-1:0]     ch_q, ch_d;
  logic              go_left_q, go_left_d;
  logic [DATA_W-1:0] m2k_q, m2k_d;
  logic [NW-1:0]     clr_q, clr_d;

  // visit datapath
  logic [CW-1:0]     qlx, qrx, lox, hix;
  logic              disjoint, covered, leaf, partial, add_now;
  logic [DATA_W-1:0] delta, m_new;
  logic [LW:0]       lh_sum;
  logic [LW-1:0]     mid;
  logic [NW-1:0]     left_node, right_node;

  // pop decode
  logic              top_post;
  logic [NW-1:0]     top_node;
  logic              adv, adv_left;

  assign qlx = CW'(ql_q);
  assign qrx = CW'(qr_q);
  assign lox = CW'(lo_q);
  assign hix = CW'(hi_q);

  assign disjoint   = (qlx > hix) || (qrx < lox);
  assign covered    = !disjoint && (qlx <= lox) && (qrx >= hix);
  assign leaf       = node_q[NW-1];
  assign partial    = !disjoint && !covered && !leaf;
  assign add_now    = covered && is_add_q;
  assign delta      = mem_rdata_i.pd + (add_now ? amt_q : '0);
  assign m_new      = mem_rdata_i.mx + delta;
  assign lh_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lh_sum[LW:1];
  assign left_node  = {node_q[NW-2:0], 1'b0};
  assign right_node = {node_q[NW-2:0], 1'b1};

  assign post_entry_o  = {1'b1, node_q, lo_q, hi_q};
  assign right_entry_o = {1'b0, right_node, mid + LW'(1), hi_q};

  assign top_post = stk_top_i[EW-1];
  assign top_node = stk_top_i[EW-2 -: NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    post_q    <= post_d;
    node_q    <= node_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    ql_q      <= ql_d;
    qr_q      <= qr_d;
    amt_q     <= amt_d;
    is_add_q  <= is_add_d;
    best_q    <= best_d;
    hit_q     <= hit_d;
    delta_q   <= delta_d;
    ch_q      <= ch_d;
    go_left_q <= go_left_d;
    m2k_q     <= m2k_d;
  end

  always_comb begin
    state_d     = state_q;
    post_d      = post_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ql_d        = ql_q;
    qr_d        = qr_q;
    amt_d       = amt_q;
    is_add_d    = is_add_q;
    best_d      = best_q;
    hit_d       = hit_q;
    delta_d     = delta_q;
    ch_d        = ch_q;
    go_left_d   = go_left_q;
    m2k_d       = m2k_q;
    clr_d       = clr_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = '0;
    mem_raddr_o = node_q;
    push_post_o = 1'b0;
    push_right_o = 1'b0;
    pop_o       = 1'b0;
    res_o.valid     = 1'b0;
    res_o.max_value = hit_q ? best_q : EMPTY_MAX;
    res_o.empty     = !hit_q;
    adv         = 1'b0;
    adv_left    = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + NW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = NW'(1);
        if (in_valid_i) begin
          ql_d     = left_index_i;
          qr_d     = right_index_i;
          amt_d    = add_amount_i;
          hit_d    = 1'b0;
          best_d   = EMPTY_MAX;
          post_d   = 1'b0;
          node_d   = NW'(1);
          lo_d     = '0;
          hi_d     = '1;
          is_add_d = (command_i == CMD_ADD);
          case (command_i)
            CMD_ADD, CMD_MAX: state_d = ST_VISIT;
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_VISIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = node_q;
        mem_wdata_o = '{mx: m_new, pd: '0};
        delta_d     = delta;
        ch_d        = left_node;
        go_left_d   = partial;
        if (covered && !is_add_q) begin
          best_d = hit_q ? smax(best_q, mem_rdata_i.mx + mem_rdata_i.pd)
                         : mem_rdata_i.mx + mem_rdata_i.pd;
          hit_d  = 1'b1;
        end
        if (partial) begin
          push_post_o  = is_add_q;
          push_right_o = 1'b1;
          node_d       = left_node;
          hi_d         = mid;
        end
        // children only need a write when something is handed down
        if (!leaf && (delta != '0)) begin
          mem_raddr_o = left_node;
          state_d     = ST_CH0;
        end else begin
          adv      = 1'b1;
          adv_left = partial;
        end
      end
      ST_CH0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ch_q;
        mem_wdata_o = '{mx: mem_rdata_i.mx, pd: mem_rdata_i.pd + delta_q};
        mem_raddr_o = ch_q | NW'(1);
        state_d     = ST_CH1;
      end
      ST_CH1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ch_q | NW'(1);
        mem_wdata_o = '{mx: mem_rdata_i.mx, pd: mem_rdata_i.pd + delta_q};
        adv         = 1'b1;
        adv_left    = go_left_q;
      end
      ST_POST0: begin
        m2k_d       = mem_rdata_i.mx;
        mem_raddr_o = right_node;
        state_d     = ST_POST1;
      end
      ST_POST1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = node_q;
        mem_wdata_o = '{mx: smax(m2k_q, mem_rdata_i.mx), pd: '0};
        adv         = 1'b1;
      end
      ST_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (adv) begin
      if (adv_left) begin
        mem_raddr_o = node_d;
        state_d     = ST_VISIT;
      end else if (!stk_empty_i) begin
        pop_o       = 1'b1;
        post_d      = top_post;
        node_d      = top_node;
        lo_d        = stk_top_i[2*LW-1 -: LW];
        hi_d        = stk_top_i[LW-1:0];
        // a post visit starts from the left child's maximum
        mem_raddr_o = top_post ? {top_node[NW-2:0], 1'b0} : top_node;
        state_d     = top_post ? ST_POST0 : ST_VISIT;
      end else begin
        state_d = is_add_q ? ST_IDLE : ST_DONE;
      end
    end
  end

endmodule

// ----- rtl/range_add_range_max_tree_unit.sv -----
// top level of the range add / range max lazy segment tree
// depends on rarmt_pkg, rarmt_mem, rarmt_stack, rarmt_ctrl
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o | command_i, left_index_i, right_index_i,
//          |                         | add_amount_i
//  out     | out_valid_o/out_ready_i | max_value_o, empty_range_o (queries only)
//
// one item at a time; each node visit takes ST_VISIT, followed by ST_CH0 and ST_CH1
// when a pending add is handed to the children; an add also rebuilds each split node
// in ST_POST0 and ST_POST1. the walk is split into these states by the single read /
// single write port of the store. after reset and on clear, a sweep over all 2*LEAVES
// entries zeroes the store; no beat is taken meanwhile. a query result waits in the
// output register; the walk stalls at its end only if that register is still full.
module range_add_range_max_tree_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [rarmt_pkg::IDX_W-1:0]         left_index_i,
  input  logic [rarmt_pkg::IDX_W-1:0]         right_index_i,
  input  logic signed [rarmt_pkg::DATA_W-1:0] add_amount_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rarmt_pkg::DATA_W-1:0] max_value_o,
  output logic                                empty_range_o
);
  import rarmt_pkg::*;

  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned NW = LW + 1;
  localparam int unsigned EW = 1 + NW + 2 * LW;
  localparam int unsigned SD = 2 * LW;

  logic          mem_we;
  logic [NW-1:0] mem_waddr, mem_raddr;
  node_t         mem_wdata, mem_rdata;
  logic          push_post, push_right, pop, stk_empty;
  logic [EW-1:0] post_entry, right_entry, stk_top;
  res_t          res;
  logic          res_ready;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_max_q;
  logic              out_empty_q;

  rarmt_ctrl #(.LEAVES(LEAVES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .left_index_i (left_index_i),
    .right_index_i(right_index_i),
    .add_amount_i (add_amount_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .push_post_o  (push_post),
    .post_entry_o (post_entry),
    .push_right_o (push_right),
    .right_entry_o(right_entry),
    .pop_o        (pop),
    .stk_top_i    (stk_top),
    .stk_empty_i  (stk_empty),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  rarmt_mem #(.AW(NW), .DW($bits(node_t))) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rarmt_stack #(.EW(EW), .SD(SD)) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(push_post),
    .data_a_i(post_entry),
    .push_b_i(push_right),
    .data_b_i(right_entry),
    .pop_i   (pop),
    .top_o   (stk_top),
    .empty_o (stk_empty)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_max_q   <= res.max_value;
      out_empty_q <= res.empty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign max_value_o   = out_max_q;
  assign empty_range_o = out_empty_q;

endmodule

// ----- rtl/rarmt_checker.sv -----
// port-level checks for range_add_range_max_tree_unit, attached by bind
// depends on rarmt_pkg and range_add_range_max_tree_unit_defines.svh
`include "range_add_range_max_tree_unit_defines.svh"

module rarmt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [1:0]                          command_i,
  input logic [rarmt_pkg::IDX_W-1:0]         left_index_i,
  input logic [rarmt_pkg::IDX_W-1:0]         right_index_i,
  input logic signed [rarmt_pkg::DATA_W-1:0] add_amount_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [rarmt_pkg::DATA_W-1:0] max_value_o,
  input logic                                empty_range_o
);
  import rarmt_pkg::*;

  // held result beat keeps valid and payload
  `RARMT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out beat dropped")
  `RARMT_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(max_value_o) && $stable(empty_range_o), "out payload changed")
  // an empty range always carries the sentinel
  `RARMT_ASSERT_IMP(a_empty_sentinel, out_valid_o && empty_range_o, max_value_o == EMPTY_MAX, "empty range without sentinel")
  // a real command keeps the unit busy for at least the next cycle
  `RARMT_ASSERT_NXT(a_busy_after_cmd, in_valid_i && in_ready_o && (command_i == CMD_ADD || command_i == CMD_MAX || command_i == CMD_CLEAR), !in_ready_o, "ready right after a command")

endmodule

bind range_add_range_max_tree_unit rarmt_checker u_rarmt_checker (.*);
